// File: rtl/core/fparm_pkg.sv
// Shared types, codes and match functions of the file path access rule matcher.
package fparm_pkg;

    // Upper bounds on the widths of rule and word indexes carried between modules.
    localparam int RULE_IDX_MAX_W = 6;
    localparam int POS_IDX_MAX_W  = 5;

    // Byte-wise NUL detection constants.
    localparam logic [63:0] BYTE_ONES  = 64'h0101010101010101;
    localparam logic [63:0] BYTE_HIGHS = 64'h8080808080808080;

    // Permission bits.
    localparam logic [2:0] PERM_R = 3'h1;
    localparam logic [2:0] PERM_W = 3'h2;
    localparam logic [2:0] PERM_X = 3'h4;

    // Request kinds.
    localparam logic [1:0] REQ_RULE_LOAD    = 2'd0;
    localparam logic [1:0] REQ_BLOCKED_LOAD = 2'd1;
    localparam logic [1:0] REQ_ACCESS       = 2'd2;

    // Match status codes.
    localparam logic [1:0] ST_UNDECIDED = 2'd0;
    localparam logic [1:0] ST_MATCH     = 2'd1;
    localparam logic [1:0] ST_FAIL      = 2'd2;

    // Verdict codes.
    localparam logic [1:0] VERDICT_ALLOW     = 2'd0;
    localparam logic [1:0] VERDICT_DENY      = 2'd1;
    localparam logic [1:0] VERDICT_ALLOW_LOG = 2'd2;

    // Reason codes.
    localparam logic [2:0] RSN_NO_POLICY  = 3'd0;
    localparam logic [2:0] RSN_BLOCKED    = 3'd1;
    localparam logic [2:0] RSN_NO_PERM    = 3'd2;
    localparam logic [2:0] RSN_RULE_OK    = 3'd3;
    localparam logic [2:0] RSN_RULE_DENY  = 3'd4;
    localparam logic [2:0] RSN_NO_RULE    = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_POLICY_EN  = 3'd0;
    localparam logic [2:0] CFG_BLOCKED_EN = 3'd1;
    localparam logic [2:0] CFG_RULE_COUNT = 3'd2;
    localparam logic [2:0] CFG_ENF_MODE   = 3'd3;
    localparam logic [2:0] CFG_DEF_ALLOW  = 3'd4;

    // Write request into the rule store.
    typedef struct packed {
        logic                      en;
        logic [RULE_IDX_MAX_W-1:0] rule;
        logic [POS_IDX_MAX_W-1:0]  pos;
        logic [63:0]               word;
        logic                      prefix;
        logic [2:0]                perm;
    } t_rule_wr;

    // Read request into the rule store.
    typedef struct packed {
        logic [RULE_IDX_MAX_W-1:0] rule;
        logic [POS_IDX_MAX_W-1:0]  pos;
    } t_rule_rd;

    // Registered read data from the rule store.
    typedef struct packed {
        logic [63:0] pattern;
        logic        prefix;
        logic [2:0]  perm;
    } t_rule_data;

    // Flags the high bit of every zero byte.
    function automatic logic [63:0] zero_flags(input logic [63:0] v);
        return (v - BYTE_ONES) & ~v & BYTE_HIGHS;
    endfunction

    // Whole-word comparison that ends at the path's NUL.
    function automatic logic [1:0] exact_step(input logic [63:0] a, input logic [63:0] b);
        logic [1:0] st;
        if (a != b) begin
            st = ST_FAIL;
        end else if (zero_flags(a) != 64'd0) begin
            st = ST_MATCH;
        end else begin
            st = ST_UNDECIDED;
        end
        return st;
    endfunction

    // Comparison that ends at the pattern's NUL.
    function automatic logic [1:0] prefix_step(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] z;
        logic [63:0] lowest;
        logic [63:0] mask;
        logic [1:0]  st;
        z      = zero_flags(b);
        lowest = z & (~z + 64'd1);
        mask   = (lowest >> 7) - 64'd1;
        if (z != 64'd0) begin
            st = ((a & mask) == (b & mask)) ? ST_MATCH : ST_FAIL;
        end else begin
            st = (a != b) ? ST_FAIL : ST_UNDECIDED;
        end
        return st;
    endfunction

endpackage

// File: rtl/core/file_path_access_rule_matcher.sv
// Top level of the file path access rule matcher: sequencer, statuses and verdict.
//
// Channel  | Dir | Fields
// s_axis   | in  | tuser: req_type; tlast: last_word; tdata: rule and path word fields
// m_axis   | out | tdata: verdict, reason, matched_rule
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data: register writes
//
// A load item is accepted in the idle state and leaves the block ready. An access word
// processes P word positions, where P is the number of positions it covers (gap fill
// included); each position sweeps all rules through the single read port of the pattern
// memory. A last word also fills to PATTERN_WORDS, then scans statuses one rule per
// cycle and decides once the output register is free.
// Reset is synchronous and clears statuses, configuration and control state; patterns and item data are not cleared.
// A result waits in the output register; a further result stalls until it is taken.
module file_path_access_rule_matcher #(
    parameter int NUM_RULES     = 16,
    parameter int PATTERN_WORDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: rule_index[3:0], word_index[6:4], path_word[70:7], match_prefix[71],
    //        perm_allowed[74:72], access_mode[77:75], path_valid[78], zero[79]
    input  logic [79:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: verdict[1:0], reason[4:2], matched_rule[8:5], zero[15:9]
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    import fparm_pkg::*;

    localparam int IW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int PWW = (PATTERN_WORDS > 1) ? $clog2(PATTERN_WORDS) : 1;
    localparam int CW  = $clog2(NUM_RULES + 1);
    localparam int CPW0 = $clog2(PATTERN_WORDS + 1);
    localparam int EW  = (CPW0 > 4) ? CPW0 : 4;
    localparam int SW  = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PROC   = 2'd1;
    localparam logic [1:0] S_FIND   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    // Input field views.
    logic [3:0]  in_rule;
    logic [2:0]  in_widx;
    logic [63:0] in_word;
    logic        in_prefix;
    logic [2:0]  in_perm;
    logic [2:0]  in_mode;
    logic        in_pvalid;

    assign in_rule   = s_axis_tdata[3:0];
    assign in_widx   = s_axis_tdata[6:4];
    assign in_word   = s_axis_tdata[70:7];
    assign in_prefix = s_axis_tdata[71];
    assign in_perm   = s_axis_tdata[74:72];
    assign in_mode   = s_axis_tdata[77:75];
    assign in_pvalid = s_axis_tdata[78];

    // Configuration registers.
    logic       r_policy_en;
    logic       r_blocked_en;
    logic [4:0] r_rule_count;
    logic       r_enf_mode;
    logic       r_def_allow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_en  <= 1'b0;
            r_blocked_en <= 1'b0;
            r_rule_count <= 5'd0;
            r_enf_mode   <= 1'b0;
            r_def_allow  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLICY_EN:  r_policy_en  <= i_cfg_data[0];
                CFG_BLOCKED_EN: r_blocked_en <= i_cfg_data[0];
                CFG_RULE_COUNT: r_rule_count <= i_cfg_data;
                CFG_ENF_MODE:   r_enf_mode   <= i_cfg_data[0];
                CFG_DEF_ALLOW:  r_def_allow  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control and item registers.
    logic [1:0]      r_state, n_state;
    logic [EW-1:0]   r_pos, n_pos;
    logic [EW-1:0]   r_end, n_end;
    logic [EW-1:0]   r_nwe, n_nwe;
    logic [CW-1:0]   r_k, n_k;
    logic            r_upd_v, n_upd_v;
    logic [IW-1:0]   r_upd_rule, n_upd_rule;
    logic [2:0]      r_widx;
    logic [63:0]     r_word;
    logic            r_last;
    logic [2:0]      r_mode;
    logic            r_pvalid;
    logic            r_found, n_found;
    logic [IW-1:0]   r_match, n_match;
    logic [1:0]      r_status [NUM_RULES];
    logic [1:0]      r_blk_status;
    logic [63:0]     r_blk_pat [PATTERN_WORDS];
    logic            r_out_v;
    logic [8:0]      r_out;

    t_rule_wr   rule_wr;
    t_rule_rd   rule_rd;
    t_rule_data rule_q;

    logic          accept;
    logic          slot_free;
    logic [EW-1:0] widx_e;
    logic [EW-1:0] acc_start;
    logic [EW-1:0] acc_end;
    logic          cur_use_data;
    logic [63:0]   cur_word;
    logic [1:0]    rule_step;
    logic [SW-1:0] count;
    logic          pos_done;
    logic          status_clear;
    logic          st_hit;

    fparm_rule_store #(
        .NUM_RULES     (NUM_RULES),
        .PATTERN_WORDS (PATTERN_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (rule_wr),
        .i_rd      (rule_rd),
        .o_rd_data (rule_q)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_v || m_axis_tready;

    // Rule load write into the store.
    always_comb begin
        rule_wr.en     = accept && (s_axis_tuser == REQ_RULE_LOAD)
                         && (7'(in_rule) < 7'(NUM_RULES))
                         && (EW'(in_widx) < EW'(PATTERN_WORDS));
        rule_wr.rule   = RULE_IDX_MAX_W'(in_rule);
        rule_wr.pos    = POS_IDX_MAX_W'(in_widx);
        rule_wr.word   = in_word;
        rule_wr.prefix = in_prefix;
        rule_wr.perm   = in_perm;
    end

    // Read address: pattern sweep during processing, attributes during the scan.
    always_comb begin
        rule_rd.rule = RULE_IDX_MAX_W'(r_k[IW-1:0]);
        rule_rd.pos  = POS_IDX_MAX_W'(r_pos[PWW-1:0]);
    end

    // Positions an access word covers.
    always_comb begin
        logic [EW-1:0] nwe_eff;
        logic [EW-1:0] plus1;
        widx_e  = EW'(in_widx);
        plus1   = widx_e + EW'(1);
        nwe_eff = (in_widx == 3'd0) ? EW'(0) : r_nwe;
        acc_start = nwe_eff;
        if (s_axis_tlast) begin
            acc_end = EW'(PATTERN_WORDS);
        end else if (widx_e >= nwe_eff) begin
            acc_end = (plus1 > EW'(PATTERN_WORDS)) ? EW'(PATTERN_WORDS) : plus1;
        end else begin
            acc_end = nwe_eff;
        end
    end

    // Word seen at the current position: data at its own index, zero in gaps.
    assign cur_use_data = (r_pos == EW'(r_widx));
    assign cur_word     = cur_use_data ? r_word : 64'd0;
    assign rule_step    = rule_q.prefix ? prefix_step(cur_word, rule_q.pattern)
                                        : exact_step(cur_word, rule_q.pattern);
    assign pos_done     = (r_k == CW'(NUM_RULES));
    assign count        = (SW'(r_rule_count) > SW'(NUM_RULES)) ? SW'(NUM_RULES)
                                                               : SW'(r_rule_count);
    assign st_hit       = (r_status[r_k[IW-1:0]] == ST_MATCH);
    assign status_clear = (accept && (s_axis_tuser == REQ_ACCESS) && (in_widx == 3'd0))
                          || ((r_state == S_DECIDE) && slot_free);

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_end      = r_end;
        n_nwe      = r_nwe;
        n_k        = r_k;
        n_upd_v    = 1'b0;
        n_upd_rule = r_k[IW-1:0];
        n_found    = r_found;
        n_match    = r_match;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (s_axis_tuser == REQ_ACCESS)) begin
                    n_pos   = acc_start;
                    n_end   = acc_end;
                    n_nwe   = acc_end;
                    n_k     = CW'(0);
                    n_found = 1'b0;
                    n_match = IW'(0);
                    if (acc_start != acc_end) begin
                        n_state = S_PROC;
                    end else if (s_axis_tlast) begin
                        n_state = S_FIND;
                    end
                end
            end
            S_PROC: begin
                n_upd_v = !pos_done;
                if (pos_done) begin
                    n_k = CW'(0);
                    if (r_pos + EW'(1) == r_end) begin
                        n_state = r_last ? S_FIND : S_IDLE;
                    end else begin
                        n_pos = r_pos + EW'(1);
                    end
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_FIND: begin
                if (!r_pvalid || (SW'(r_k) >= count)) begin
                    n_state = S_DECIDE;
                end else if (st_hit) begin
                    n_found = 1'b1;
                    n_match = r_k[IW-1:0];
                    n_state = S_DECIDE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_DECIDE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                    n_nwe   = EW'(0);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nwe   <= EW'(0);
            r_upd_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nwe   <= n_nwe;
            r_upd_v <= n_upd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_end      <= n_end;
        r_k        <= n_k;
        r_upd_rule <= n_upd_rule;
        r_found    <= n_found;
        r_match    <= n_match;
        if (accept) begin
            r_widx   <= in_widx;
            r_word   <= in_word;
            r_last   <= s_axis_tlast;
            r_mode   <= in_mode;
            r_pvalid <= in_pvalid;
        end
    end

    // Blocked path pattern words.
    always_ff @(posedge i_clk) begin
        if (accept && (s_axis_tuser == REQ_BLOCKED_LOAD)
            && (EW'(in_widx) < EW'(PATTERN_WORDS))) begin
            r_blk_pat[in_widx[PWW-1:0]] <= in_word;
        end
    end

    // Match statuses: read, update and write back one rule per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || status_clear) begin
            for (int i = 0; i < NUM_RULES; i++) begin
                r_status[i] <= ST_UNDECIDED;
            end
            r_blk_status <= ST_UNDECIDED;
        end else if (r_state == S_PROC) begin
            if (r_upd_v && (r_status[r_upd_rule] == ST_UNDECIDED)) begin
                r_status[r_upd_rule] <= rule_step;
            end
            if ((r_k == CW'(0)) && (r_blk_status == ST_UNDECIDED)) begin
                r_blk_status <= exact_step(cur_word, r_blk_pat[r_pos[PWW-1:0]]);
            end
        end
    end

    // Verdict and output register.
    always_ff @(posedge i_clk) begin
        logic [1:0] viol;
        logic [1:0] verdict;
        logic [2:0] reason;
        logic [3:0] matched;
        viol    = r_enf_mode ? VERDICT_ALLOW_LOG : VERDICT_DENY;
        verdict = VERDICT_ALLOW;
        reason  = RSN_NO_POLICY;
        matched = 4'd0;
        priority if (!r_policy_en) begin
            reason = RSN_NO_POLICY;
        end else if (r_blocked_en && r_pvalid && (r_blk_status == ST_MATCH)) begin
            verdict = viol;
            reason  = RSN_BLOCKED;
        end else if (r_mode == 3'd0) begin
            reason = RSN_NO_PERM;
        end else if (r_found) begin
            matched = 4'(r_match);
            if ((rule_q.perm & r_mode) != r_mode) begin
                verdict = viol;
                reason  = RSN_RULE_DENY;
            end else begin
                reason = RSN_RULE_OK;
            end
        end else begin
            verdict = r_def_allow ? VERDICT_ALLOW : viol;
            reason  = RSN_NO_RULE;
        end
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((r_state == S_DECIDE) && slot_free) begin
            r_out_v <= 1'b1;
            r_out   <= {matched, reason, verdict};
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {7'd0, r_out};

    // Checks on the sequencer.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROC) |-> (r_pos < r_end))
        else $error("position beyond end of sweep");

    a_nwe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nwe <= EW'(PATTERN_WORDS))
        else $error("next expected word beyond pattern");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DECIDE) && slot_free) |=> m_axis_tvalid)
        else $error("decided result not presented");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROC) |-> (r_k <= CW'(NUM_RULES)))
        else $error("rule sweep counter overran");

endmodule

// File: rtl/core/fparm_rule_store.sv
// Rule pattern and rule attribute memories with registered read data.
module fparm_rule_store #(
    parameter int NUM_RULES     = 16,
    parameter int PATTERN_WORDS = 8
) (
    input  logic                  i_clk,
    input  fparm_pkg::t_rule_wr   i_wr,
    input  fparm_pkg::t_rule_rd   i_rd,
    output fparm_pkg::t_rule_data o_rd_data
);
    import fparm_pkg::*;

    localparam int IW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int PWW = (PATTERN_WORDS > 1) ? $clog2(PATTERN_WORDS) : 1;
    localparam int DEPTH = 1 << (IW + PWW);

    logic [63:0] mem_pattern [DEPTH];
    logic [3:0]  mem_attr [1 << IW];

    logic [IW+PWW-1:0] wr_addr;
    logic [IW+PWW-1:0] rd_addr;

    assign wr_addr = {i_wr.rule[IW-1:0], i_wr.pos[PWW-1:0]};
    assign rd_addr = {i_rd.rule[IW-1:0], i_rd.pos[PWW-1:0]};

    // Pattern words per rule and position, prefix flag and permission mask per rule.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_pattern[wr_addr]         <= i_wr.word;
            mem_attr[i_wr.rule[IW-1:0]] <= {i_wr.prefix, i_wr.perm};
        end
        o_rd_data <= {mem_pattern[rd_addr], mem_attr[i_rd.rule[IW-1:0]]};
    end

endmodule

// File: test/tb_file_path_access_rule_matcher.sv
// Self-checking testbench for the file path access rule matcher.
module tb_file_path_access_rule_matcher;
    timeunit 1ns;
    timeprecision 1ps;
    import fparm_pkg::*;

    localparam int          N_RULES     = 16;
    localparam int          N_WORDS     = 8;
    localparam logic [1:0]  REQ_IGNORED = 2'd3;
    localparam int          DRAIN_WAIT  = 400;
    localparam int          STALL_LIMIT = 6000;

    typedef struct {
        logic [1:0]  req;
        logic [3:0]  ridx;
        logic [2:0]  widx;
        logic [63:0] word;
        logic        prefix;
        logic [2:0]  perm;
        logic [2:0]  amode;
        logic        pvalid;
        logic        last;
    } t_req_item;

    typedef struct {
        logic [1:0] verdict;
        logic [2:0] reason;
        logic [3:0] rule;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [4:0]  i_cfg_data = '0;

    file_path_access_rule_matcher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted block state.
    logic [63:0] pr_rule_pat [N_RULES][N_WORDS];
    logic        pr_rule_pfx [N_RULES];
    logic [2:0]  pr_rule_perm [N_RULES];
    logic [63:0] pr_blk_pat [N_WORDS];
    logic [1:0]  pr_rule_st [N_RULES];
    logic [1:0]  pr_blk_st;
    int          pr_next_pos;
    logic        cf_policy, cf_blocked, cf_enf, cf_def;
    logic [4:0]  cf_count;

    // Patterns as they will be once queued loads are applied; used to build paths.
    logic [511:0] plan_rule [N_RULES];
    logic [511:0] plan_blk;

    t_req_item pending_items[$];
    t_verdict  verdict_queue[$];
    int        n_mismatch = 0;
    int        n_verdicts = 0;
    int        n_items = 0;
    int        reason_seen [8];
    logic      quiet = 1'b0;
    int        s_gap = 0;
    int        m_gap = 0;
    int        idle_cycles = 0;

    function automatic logic [63:0] nul_marks(input logic [63:0] v);
        return (v - BYTE_ONES) & ~v & BYTE_HIGHS;
    endfunction

    function automatic logic [1:0] whole_cmp(input logic [63:0] a, input logic [63:0] b);
        if (a != b) return ST_FAIL;
        if (nul_marks(a) != 64'd0) return ST_MATCH;
        return ST_UNDECIDED;
    endfunction

    function automatic logic [1:0] head_cmp(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] z;
        logic [63:0] m;
        z = nul_marks(b);
        if (z != 64'd0) begin
            m = ((z & (~z + 64'd1)) >> 7) - 64'd1;
            return ((a & m) == (b & m)) ? ST_MATCH : ST_FAIL;
        end
        return (a != b) ? ST_FAIL : ST_UNDECIDED;
    endfunction

    function automatic void clear_match();
        for (int r = 0; r < N_RULES; r++) pr_rule_st[r] = ST_UNDECIDED;
        pr_blk_st = ST_UNDECIDED;
        pr_next_pos = 0;
    endfunction

    function automatic void scan_pos(input logic [63:0] a, input int pos);
        for (int r = 0; r < N_RULES; r++) begin
            if (pr_rule_st[r] == ST_UNDECIDED)
                pr_rule_st[r] = pr_rule_pfx[r] ? head_cmp(a, pr_rule_pat[r][pos])
                                               : whole_cmp(a, pr_rule_pat[r][pos]);
        end
        if (pr_blk_st == ST_UNDECIDED) pr_blk_st = whole_cmp(a, pr_blk_pat[pos]);
    endfunction

    function automatic void pad_to(input int stop);
        while (pr_next_pos < stop && pr_next_pos < N_WORDS) begin
            scan_pos(64'd0, pr_next_pos);
            pr_next_pos++;
        end
    endfunction

    // Applies one accepted item to the predicted state; queues a verdict if one is due.
    function automatic void predict_verdict(input t_req_item it);
        t_verdict   v;
        logic [1:0] bad;
        int         cnt;
        logic       found;
        if (it.req == REQ_RULE_LOAD) begin
            pr_rule_pat[it.ridx][it.widx] = it.word;
            pr_rule_pfx[it.ridx] = it.prefix;
            pr_rule_perm[it.ridx] = it.perm;
            return;
        end
        if (it.req == REQ_BLOCKED_LOAD) begin
            pr_blk_pat[it.widx] = it.word;
            return;
        end
        if (it.req != REQ_ACCESS) return;
        if (it.widx == 0) clear_match();
        if (int'(it.widx) >= pr_next_pos) begin
            pad_to(int'(it.widx));
            scan_pos(it.word, int'(it.widx));
            pr_next_pos = int'(it.widx) + 1;
        end
        if (!it.last) return;
        pad_to(N_WORDS);
        bad = cf_enf ? VERDICT_ALLOW_LOG : VERDICT_DENY;
        v.rule = 4'd0;
        found = 1'b0;
        if (!cf_policy) begin
            v.verdict = VERDICT_ALLOW; v.reason = RSN_NO_POLICY;
        end else if (cf_blocked && it.pvalid && pr_blk_st == ST_MATCH) begin
            v.verdict = bad; v.reason = RSN_BLOCKED;
        end else if (it.amode == 3'd0) begin
            v.verdict = VERDICT_ALLOW; v.reason = RSN_NO_PERM;
        end else begin
            if (it.pvalid) begin
                cnt = (int'(cf_count) < N_RULES) ? int'(cf_count) : N_RULES;
                for (int r = 0; r < cnt; r++) begin
                    if (!found && pr_rule_st[r] == ST_MATCH) begin
                        found = 1'b1;
                        v.rule = 4'(r);
                    end
                end
            end
            if (found) begin
                if ((pr_rule_perm[v.rule] & it.amode) != it.amode) begin
                    v.verdict = bad; v.reason = RSN_RULE_DENY;
                end else begin
                    v.verdict = VERDICT_ALLOW; v.reason = RSN_RULE_OK;
                end
            end else begin
                v.verdict = cf_def ? VERDICT_ALLOW : bad;
                v.reason = RSN_NO_RULE;
            end
        end
        clear_match();
        verdict_queue.push_back(v);
    endfunction

    // Sender: predicts each accepted item and presents queued items, with random idle bursts.
    always @(posedge i_clk) begin
        t_req_item it;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                it.req = s_axis_tuser;
                it.ridx = s_axis_tdata[3:0];
                it.widx = s_axis_tdata[6:4];
                it.word = s_axis_tdata[70:7];
                it.prefix = s_axis_tdata[71];
                it.perm = s_axis_tdata[74:72];
                it.amode = s_axis_tdata[77:75];
                it.pvalid = s_axis_tdata[78];
                it.last = s_axis_tlast;
                predict_verdict(it);
                n_items++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    s_gap = $urandom_range(0, 18);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_axis_tdata <= {1'b0, it.pvalid, it.amode, it.perm, it.prefix,
                                     it.word, it.widx, it.ridx};
                    s_axis_tuser <= it.req;
                    s_axis_tlast <= it.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, and the check of each verdict against the oldest prediction.
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_queue.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("Unexpected verdict item: %h", m_axis_tdata);
                end else begin
                    exp_v = verdict_queue.pop_front();
                    n_verdicts++;
                    reason_seen[exp_v.reason]++;
                    if (m_axis_tdata[1:0] !== exp_v.verdict || m_axis_tdata[4:2] !== exp_v.reason
                        || m_axis_tdata[8:5] !== exp_v.rule) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("Mismatch: expected verdict %0d reason %0d rule %0d, got %0d %0d %0d",
                                     exp_v.verdict, exp_v.reason, exp_v.rule, m_axis_tdata[1:0],
                                     m_axis_tdata[4:2], m_axis_tdata[8:5]);
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_gap = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random C string of up to max_len bytes, NUL padded.
    function automatic logic [511:0] rand_string(input int max_len);
        logic [511:0] s;
        int len;
        s = '0;
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++) s[8*i +: 8] = 8'($urandom_range(1, 255));
        return s;
    endfunction

    task automatic push_item(input logic [1:0] req, input int ridx, input int widx,
                             input logic [63:0] word, input logic prefix, input logic [2:0] perm,
                             input logic [2:0] amode, input logic pvalid, input logic last);
        t_req_item it;
        it.req = req; it.ridx = 4'(ridx); it.widx = 3'(widx); it.word = word;
        it.prefix = prefix; it.perm = perm; it.amode = amode;
        it.pvalid = pvalid; it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic load_rule(input int r, input logic [511:0] s, input logic pfx,
                             input logic [2:0] perm);
        plan_rule[r] = s;
        for (int w = 0; w < N_WORDS; w++)
            push_item(REQ_RULE_LOAD, r, w, s[64*w +: 64], pfx, perm,
                      $urandom, $urandom, $urandom);
    endtask

    task automatic load_blocked(input logic [511:0] s);
        plan_blk = s;
        for (int w = 0; w < N_WORDS; w++)
            push_item(REQ_BLOCKED_LOAD, $urandom, w, s[64*w +: 64], $urandom, $urandom,
                      $urandom, $urandom, $urandom);
    endtask

    // Streams a path up to the word holding its NUL (or a random further word).
    // style: 0 in order, 1 gap, 2 repeated old word, 3 restart midway, 4 no last on the path's own words.
    task automatic send_path(input logic [511:0] s, input logic [2:0] amode,
                             input logic pvalid, input int style);
        int k;
        int w;
        k = 7;
        for (int i = 7; i >= 0; i--)
            if (nul_marks(s[64*i +: 64]) != 64'd0) k = i;
        if ($urandom_range(0, 5) == 0) k = $urandom_range(k, 7);
        if (style == 3) begin
            push_item(REQ_ACCESS, $urandom, 0, $urandom, $urandom, $urandom, amode, pvalid, 1'b0);
            if ($urandom_range(0, 1)) push_item(REQ_ACCESS, $urandom, 1, {$urandom, $urandom},
                                                $urandom, $urandom, amode, pvalid, 1'b0);
        end
        w = 0;
        while (w <= k) begin
            if (style == 1 && w > 0 && w < k && $urandom_range(0, 2) == 0) begin
                w++;
                continue;
            end
            push_item(REQ_ACCESS, $urandom, w, s[64*w +: 64], $urandom, $urandom,
                      amode, pvalid, (w == k) && style != 4);
            if (style == 2 && w > 0 && $urandom_range(0, 2) == 0)
                push_item(REQ_ACCESS, $urandom, $urandom_range(1, w), {$urandom, $urandom},
                          $urandom, $urandom, amode, pvalid, 1'b0);
            w++;
        end
        if (style == 4 && $urandom_range(0, 1))
            push_item(REQ_ACCESS, $urandom, $urandom_range(1, k > 0 ? k : 1),
                      {$urandom, $urandom}, $urandom, $urandom, amode, pvalid, 1'b1);
    endtask

    // Builds a path close to a stored pattern, so that rules and the blocked path match often.
    function automatic logic [511:0] near_path(input logic [511:0] src, input int how);
        logic [511:0] s;
        int p;
        s = src;
        p = 64;
        for (int i = 63; i >= 0; i--) if (s[8*i +: 8] == 8'd0) p = i;
        case (how)
            1: for (int i = p; i < 64 && i < p + $urandom_range(1, 12); i++)
                   s[8*i +: 8] = 8'($urandom_range(1, 255));
            2: if (p > 0) s[8*$urandom_range(0, p - 1) +: 8] = 8'($urandom_range(1, 255));
            3: if (p > 0) s[8*(p - 1) +: 8] = 8'd0;
            default: ;
        endcase
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || verdict_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_config(input logic pol, input logic blk, input logic [4:0] cnt,
                                input logic enf, input logic dflt);
        logic [4:0] vals [5];
        logic [2:0] idx [5];
        vals = '{5'(pol), 5'(blk), cnt, 5'(enf), 5'(dflt)};
        idx = '{CFG_POLICY_EN, CFG_BLOCKED_EN, CFG_RULE_COUNT, CFG_ENF_MODE, CFG_DEF_ALLOW};
        for (int i = 0; i < 5; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[i];
            i_cfg_data <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cf_policy = pol; cf_blocked = blk; cf_count = cnt; cf_enf = enf; cf_def = dflt;
    endtask

    initial begin
        int n_rand;
        int pick;
        logic [511:0] s;
        cf_policy = 1'b0; cf_blocked = 1'b0; cf_count = '0; cf_enf = 1'b0; cf_def = 1'b1;
        clear_match();
        for (int i = 0; i < 8; i++) reason_seen[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings first, while nothing is queued.
        write_config(1'b1, 1'b1, 5'd16, 1'b0, 1'b1);

        // Fill every rule and the blocked path before any access reads them.
        for (int r = 0; r < N_RULES; r++)
            load_rule(r, rand_string(r < 4 ? 20 : 63), $urandom, $urandom);
        load_blocked(rand_string(30));

        // Directed part: blocked path, rule hits, no permission, unresolved path,
        // gaps, old words, restarts, ignored requests, all-ones and zero words.
        send_path(plan_blk, 3'd7, 1'b1, 0);
        send_path(plan_blk, 3'd7, 1'b0, 0);
        send_path(plan_rule[0], 3'd1, 1'b1, 0);
        send_path(near_path(plan_rule[1], 1), 3'd7, 1'b1, 0);
        send_path(plan_rule[2], 3'd0, 1'b1, 0);
        send_path(plan_rule[3], 3'd6, 1'b1, 1);
        send_path(plan_rule[0], 3'd2, 1'b1, 2);
        send_path(plan_rule[1], 3'd4, 1'b1, 3);
        push_item(REQ_IGNORED, 15, 7, '1, 1'b1, 3'd7, 3'd7, 1'b1, 1'b1);
        push_item(REQ_ACCESS, 15, 0, '1, 1'b1, 3'd7, 3'd7, 1'b1, 1'b0);
        push_item(REQ_ACCESS, 0, 7, '0, 1'b0, 3'd0, 3'd7, 1'b1, 1'b1);
        push_item(REQ_ACCESS, 0, 0, '0, 1'b0, 3'd0, 3'd5, 1'b1, 1'b1);
        wait_drained();

        // Random phases under a range of settings, extremes first.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: write_config(1'b1, 1'b1, 5'd16, 1'b1, 1'b0);
                1: write_config(1'b0, 1'b0, 5'd0, 1'b0, 1'b0);
                2: write_config(1'b1, 1'b0, 5'd0, 1'b0, 1'b0);
                3: write_config(1'b1, 1'b1, 5'd31, 1'b1, 1'b1);
                4: write_config(1'b1, 1'b1, 5'd1, 1'b0, 1'b1);
                default: write_config($urandom_range(0, 7) != 0, $urandom, $urandom_range(0, 31),
                                      $urandom, $urandom);
            endcase
            quiet = (ph == 8);
            n_rand = 0;
            while (n_rand < 200) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    load_rule($urandom_range(0, 15), rand_string($urandom_range(0, 1) ? 20 : 63),
                              $urandom, $urandom);
                    n_rand += 8;
                end else if (pick < 11) begin
                    load_blocked(rand_string(40));
                    n_rand += 8;
                end else if (pick < 15) begin
                    // Noise: random single words of any kind.
                    push_item($urandom, $urandom, $urandom, {$urandom, $urandom}, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
                    n_rand++;
                end else begin
                    if (pick < 25) s = near_path(plan_blk, $urandom_range(0, 3));
                    else if (pick < 88) s = near_path(plan_rule[$urandom_range(0, 15)],
                                                       $urandom_range(0, 3));
                    else s = rand_string(63);
                    send_path(s, $urandom, $urandom_range(0, 9) != 0,
                              $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 4));
                    n_rand += 4;
                end
                // Keep the queue short so that idle bursts spread across the run.
                while (pending_items.size() > 40) @(posedge i_clk);
            end
            wait_drained();
        end

        $display("Covered %0d items and %0d verdicts over ten settings; reasons seen:", n_items,
                 n_verdicts);
        $display("  no policy %0d, blocked %0d, no perm %0d, permits %0d, forbids %0d, no rule %0d",
                 reason_seen[0], reason_seen[1], reason_seen[2], reason_seen[3], reason_seen[4],
                 reason_seen[5]);
        if (n_mismatch == 0 && verdict_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d verdicts missing", n_mismatch, verdict_queue.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
